[hdl/qfr_pkg.sv]
// Shared constants, types and codes for the rotation-matrix-to-quaternion core.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps

package qfr_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = DATA_WIDTH - 2;
    localparam int SCALE_SH    = FRAC_BITS - 2;
    localparam int MAT_N       = 9;
    localparam int ARG_W       = DATA_WIDTH + 2;
    localparam int A_W         = DATA_WIDTH + 1;
    localparam int NUM_W       = DATA_WIDTH + 1;
    localparam int RAD_W       = 2 * DATA_WIDTH;
    localparam int ROOT_W      = DATA_WIDTH;
    localparam int REM_W       = DATA_WIDTH + 4;
    localparam int SQ_STAGES   = DATA_WIDTH;
    localparam int DIVD_W      = 2 * DATA_WIDTH - 1;
    localparam int PREM_W      = DATA_WIDTH + 1;
    localparam int IN_TDATA_W  = ((MAT_N * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((4 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 3;

    typedef enum logic [1:0] {
        PIV_X = 2'd0,
        PIV_Y = 2'd1,
        PIV_Z = 2'd2,
        PIV_W = 2'd3
    } pivot_t;

    typedef struct packed {
        pivot_t pivot;
        logic   degen;
    } side_t;

    typedef logic signed [DATA_WIDTH-1:0] elem_t;

endpackage

[hdl/qfr_front.sv]
// Front end: trace, pivot choice, square root argument and numerators (two stages).
// Depends on qfr_pkg.
`timescale 1ns / 1ps

module qfr_front
    import qfr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      ce,
    input  logic                      in_valid,
    input  elem_t                     m [MAT_N],
    output logic                      out_valid,
    output side_t                     out_side,
    output logic [A_W-1:0]            out_a,
    output logic [2:0][NUM_W-1:0]     out_num
);

    localparam logic signed [ARG_W-1:0] ARG_ONE = ARG_W'(1) << FRAC_BITS;

    elem_t                  m1_reg [MAT_N];
    pivot_t                 piv1_reg, piv1_next;
    logic                   v1_reg;

    logic signed [ARG_W-1:0] trace;
    logic signed [ARG_W-1:0] d0, d4, d8, arg;
    logic signed [NUM_W-1:0] e1, e2, e3, e5, e6, e7;
    logic [2:0][NUM_W-1:0]   num_next;
    logic                    degen_next;

    logic                    v2_reg;
    side_t                   side2_reg;
    logic [A_W-1:0]          a2_reg;
    logic [2:0][NUM_W-1:0]   num2_reg;

    always_comb
    begin
        trace = ARG_W'(m[0]) + ARG_W'(m[4]) + ARG_W'(m[8]);
        if (!trace[ARG_W-1] && (trace != '0))
        begin
            piv1_next = PIV_W;
        end
        else if (m[8] > ((m[4] > m[0]) ? m[4] : m[0]))
        begin
            piv1_next = PIV_Z;
        end
        else if (m[4] > m[0])
        begin
            piv1_next = PIV_Y;
        end
        else
        begin
            piv1_next = PIV_X;
        end
    end

    always_comb
    begin
        d0 = ARG_W'(m1_reg[0]);
        d4 = ARG_W'(m1_reg[4]);
        d8 = ARG_W'(m1_reg[8]);
        e1 = NUM_W'(m1_reg[1]);
        e2 = NUM_W'(m1_reg[2]);
        e3 = NUM_W'(m1_reg[3]);
        e5 = NUM_W'(m1_reg[5]);
        e6 = NUM_W'(m1_reg[6]);
        e7 = NUM_W'(m1_reg[7]);
        unique case (piv1_reg)
            PIV_W:
            begin
                arg         = d0 + d4 + d8 + ARG_ONE;
                num_next[0] = e5 - e7;
                num_next[1] = e6 - e2;
                num_next[2] = e1 - e3;
            end
            PIV_X:
            begin
                arg         = d0 - d4 - d8 + ARG_ONE;
                num_next[0] = e5 - e7;
                num_next[1] = e3 + e1;
                num_next[2] = e6 + e2;
            end
            PIV_Y:
            begin
                arg         = d4 - d8 - d0 + ARG_ONE;
                num_next[0] = e6 - e2;
                num_next[1] = e7 + e5;
                num_next[2] = e1 + e3;
            end
            PIV_Z:
            begin
                arg         = d8 - d0 - d4 + ARG_ONE;
                num_next[0] = e1 - e3;
                num_next[1] = e2 + e6;
                num_next[2] = e5 + e7;
            end
            default:
            begin
                arg      = '0;
                num_next = '0;
            end
        endcase
        degen_next = arg[ARG_W-1] || (arg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m1_reg          <= m;
            piv1_reg        <= piv1_next;
            side2_reg.pivot <= piv1_reg;
            side2_reg.degen <= degen_next;
            a2_reg          <= degen_next ? '0 : arg[A_W-1:0];
            num2_reg        <= num_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = side2_reg;
    assign out_a     = a2_reg;
    assign out_num   = num2_reg;

endmodule

[hdl/qfr_sqrt.sv]
// Pipelined restoring square root, one root bit per stage, numerators carried alongside.
// Depends on qfr_pkg.
`timescale 1ns / 1ps

module qfr_sqrt
    import qfr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      ce,
    input  logic                      in_valid,
    input  side_t                     in_side,
    input  logic [A_W-1:0]            in_a,
    input  logic [2:0][NUM_W-1:0]     in_num,
    output logic                      out_valid,
    output side_t                     out_side,
    output logic [ROOT_W-1:0]         out_root,
    output logic [2:0][NUM_W-1:0]     out_num
);

    logic [RAD_W-1:0]          rad_reg  [SQ_STAGES];
    logic [REM_W-1:0]          rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0]         root_reg [SQ_STAGES];
    logic [2:0][NUM_W-1:0]     num_reg  [SQ_STAGES];
    side_t                     side_reg [SQ_STAGES];
    logic [SQ_STAGES-1:0]      vld_reg;

    logic [RAD_W-1:0]          rad_next  [SQ_STAGES];
    logic [REM_W-1:0]          rem_next  [SQ_STAGES];
    logic [ROOT_W-1:0]         root_next [SQ_STAGES];
    logic [2:0][NUM_W-1:0]     num_next  [SQ_STAGES];
    side_t                     side_next [SQ_STAGES];
    logic [SQ_STAGES-1:0]      vld_next;

    always_comb
    begin
        logic [RAD_W-1:0]  rad_i;
        logic [REM_W-1:0]  rem_i;
        logic [ROOT_W-1:0] root_i;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            if (k == 0)
            begin
                rad_i        = RAD_W'(in_a) << SCALE_SH;
                rem_i        = '0;
                root_i       = '0;
                num_next[k]  = in_num;
                side_next[k] = in_side;
                vld_next[k]  = in_valid;
            end
            else
            begin
                rad_i        = rad_reg[k-1];
                rem_i        = rem_reg[k-1];
                root_i       = root_reg[k-1];
                num_next[k]  = num_reg[k-1];
                side_next[k] = side_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
            end
            rem_sh       = {rem_i[REM_W-3:0], rad_i[RAD_W-1:RAD_W-2]};
            trial        = (REM_W'(root_i) << 2) | REM_W'(1);
            ge           = (rem_sh >= trial);
            rem_next[k]  = ge ? (rem_sh - trial) : rem_sh;
            root_next[k] = {root_i[ROOT_W-2:0], ge};
            rad_next[k]  = rad_i << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            num_reg  <= num_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1];
    assign out_num   = num_reg[SQ_STAGES-1];

endmodule

[hdl/qfr_div.sv]
// Three-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// Depends on qfr_pkg.
`timescale 1ns / 1ps

module qfr_div
    import qfr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      ce,
    input  logic                      in_valid,
    input  side_t                     in_side,
    input  logic [ROOT_W-1:0]         in_root,
    input  logic [2:0][NUM_W-1:0]     in_num,
    output logic                      out_valid,
    output side_t                     out_side,
    output logic [ROOT_W-1:0]         out_root,
    output logic [2:0][ROOT_W-1:0]    out_quot,
    output logic [2:0]                out_sat,
    output logic [2:0]                out_neg
);

    logic [2:0][DIVD_W-1:0]    dvd_reg  [DIVD_W];
    logic [2:0][PREM_W-1:0]    rem_reg  [DIVD_W];
    logic [2:0][ROOT_W-1:0]    quot_reg [DIVD_W];
    logic [2:0]                sat_reg  [DIVD_W];
    logic [2:0]                neg_reg  [DIVD_W];
    logic [ROOT_W-1:0]         root_reg [DIVD_W];
    side_t                     side_reg [DIVD_W];
    logic [DIVD_W-1:0]         vld_reg;

    logic [2:0][DIVD_W-1:0]    dvd_next  [DIVD_W];
    logic [2:0][PREM_W-1:0]    rem_next  [DIVD_W];
    logic [2:0][ROOT_W-1:0]    quot_next [DIVD_W];
    logic [2:0]                sat_next  [DIVD_W];
    logic [2:0]                neg_next  [DIVD_W];
    logic [ROOT_W-1:0]         root_next [DIVD_W];
    side_t                     side_next [DIVD_W];
    logic [DIVD_W-1:0]         vld_next;

    always_comb
    begin
        logic [NUM_W-1:0]  mag;
        logic [DIVD_W-1:0] dvd_i;
        logic [PREM_W-1:0] rem_i;
        logic [ROOT_W-1:0] quot_i;
        logic              sat_i;
        logic [PREM_W-1:0] rem_sh;
        logic              ge;
        for (int k = 0; k < DIVD_W; k++)
        begin
            if (k == 0)
            begin
                root_next[k] = in_root;
                side_next[k] = in_side;
                vld_next[k]  = in_valid;
            end
            else
            begin
                root_next[k] = root_reg[k-1];
                side_next[k] = side_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
            end
            for (int l = 0; l < 3; l++)
            begin
                if (k == 0)
                begin
                    mag            = in_num[l][NUM_W-1] ? (~in_num[l] + NUM_W'(1)) : in_num[l];
                    dvd_i          = DIVD_W'(mag) << SCALE_SH;
                    rem_i          = '0;
                    quot_i         = '0;
                    sat_i          = 1'b0;
                    neg_next[k][l] = in_num[l][NUM_W-1];
                end
                else
                begin
                    mag            = '0;
                    dvd_i          = dvd_reg[k-1][l];
                    rem_i          = rem_reg[k-1][l];
                    quot_i         = quot_reg[k-1][l];
                    sat_i          = sat_reg[k-1][l];
                    neg_next[k][l] = neg_reg[k-1][l];
                end
                rem_sh             = {rem_i[PREM_W-2:0], dvd_i[DIVD_W-1]};
                ge                 = (rem_sh >= PREM_W'(root_next[k]));
                rem_next[k][l]     = ge ? (rem_sh - PREM_W'(root_next[k])) : rem_sh;
                quot_next[k][l]    = {quot_i[ROOT_W-2:0], ge};
                sat_next[k][l]     = sat_i | quot_i[ROOT_W-1];
                dvd_next[k][l]     = dvd_i << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dvd_reg  <= dvd_next;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            sat_reg  <= sat_next;
            neg_reg  <= neg_next;
            root_reg <= root_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[DIVD_W-1];
    assign out_side  = side_reg[DIVD_W-1];
    assign out_root  = root_reg[DIVD_W-1];
    assign out_quot  = quot_reg[DIVD_W-1];
    assign out_sat   = sat_reg[DIVD_W-1];
    assign out_neg   = neg_reg[DIVD_W-1];

endmodule

[hdl/quaternion_from_rotation_matrix_core.sv]
// Pipeline: front end, square root, divider, assemble register and output register, in that order.
// Throughput: one matrix per cycle; the whole pipeline advances together and
// stalls only while the output skid register is occupied.
// Reset: rst_n asynchronous, clears all valid bits, output and skid valid included;
// data registers are not reset. Depends on qfr_pkg, qfr_front, qfr_sqrt, qfr_div.
`timescale 1ns / 1ps

module quaternion_from_rotation_matrix_core
    import qfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // col0_row0, col0_row1, ... col2_row2
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic [OUT_TUSER_W-1:0] m_tuser    // pivot_component, degenerate
);

    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [OUT_TDATA_W-1:0] data;
        logic [OUT_TUSER_W-1:0] user;
    } beat_t;

    logic                  ce;
    elem_t                 m [MAT_N];

    logic                  f_valid;
    side_t                 f_side;
    logic [A_W-1:0]        f_a;
    logic [2:0][NUM_W-1:0] f_num;

    logic                  r_valid;
    side_t                 r_side;
    logic [ROOT_W-1:0]     r_root;
    logic [2:0][NUM_W-1:0] r_num;

    logic                     d_valid;
    side_t                    d_side;
    logic [ROOT_W-1:0]        d_root;
    logic [2:0][ROOT_W-1:0]   d_quot;
    logic [2:0]               d_sat;
    logic [2:0]               d_neg;

    logic [2:0][DATA_WIDTH-1:0] lane;
    logic [DATA_WIDTH-1:0]      qx, qy, qz, qw;
    beat_t                      asm_next, asm_reg, out_reg, skid_reg;
    logic                       asm_valid_reg, out_valid_reg, skid_valid_reg;
    logic                       xfer;

    function automatic logic [DATA_WIDTH-1:0] clamp(input logic [ROOT_W-1:0] q,
                                                    input logic sat, input logic neg);
        logic [DATA_WIDTH-1:0] res;
        if (neg)
        begin
            if (sat || (q[ROOT_W-1] && (q[ROOT_W-2:0] != '0)))
                res = SAT_MIN;
            else
                res = ~q + DATA_WIDTH'(1);
        end
        else
        begin
            if (sat || q[ROOT_W-1])
                res = SAT_MAX;
            else
                res = q;
        end
        return res;
    endfunction

    always_comb
    begin
        for (int i = 0; i < MAT_N; i++)
        begin
            m[i] = s_tdata[i*DATA_WIDTH +: DATA_WIDTH];
        end
    end

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    qfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .m         (m),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_a     (f_a),
        .out_num   (f_num)
    );

    qfr_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_a      (f_a),
        .in_num    (f_num),
        .out_valid (r_valid),
        .out_side  (r_side),
        .out_root  (r_root),
        .out_num   (r_num)
    );

    qfr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (r_valid),
        .in_side   (r_side),
        .in_root   (r_root),
        .in_num    (r_num),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_root  (d_root),
        .out_quot  (d_quot),
        .out_sat   (d_sat),
        .out_neg   (d_neg)
    );

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            lane[l] = clamp(d_quot[l], d_sat[l], d_neg[l]);
        end
        unique case (d_side.pivot)
            PIV_W:
            begin
                qx = lane[0]; qy = lane[1]; qz = lane[2]; qw = d_root;
            end
            PIV_X:
            begin
                qx = d_root;  qy = lane[1]; qz = lane[2]; qw = lane[0];
            end
            PIV_Y:
            begin
                qx = lane[2]; qy = d_root;  qz = lane[1]; qw = lane[0];
            end
            PIV_Z:
            begin
                qx = lane[1]; qy = lane[2]; qz = d_root;  qw = lane[0];
            end
            default:
            begin
                qx = '0; qy = '0; qz = '0; qw = '0;
            end
        endcase
        if (d_side.degen)
        begin
            asm_next.data = '0;
        end
        else
        begin
            asm_next.data = OUT_TDATA_W'({qw, qz, qy, qx});
        end
        asm_next.user = {d_side.degen, d_side.pivot};
    end

    assign xfer = ce && asm_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (ce)
            begin
                asm_valid_reg <= d_valid;
            end
            if (!out_valid_reg || m_tready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= xfer;
                end
            end
            else if (xfer)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            asm_reg <= asm_next;
        end
        if (!out_valid_reg || m_tready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : asm_reg;
        end
        else if (xfer)
        begin
            skid_reg <= asm_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.user;

    // degenerate beats carry an all-zero quaternion
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tdata == '0))
        else $error("degenerate beat with nonzero quaternion");

    // the trace path never reports a degenerate argument
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1:0] == PIV_W)) |-> !m_tuser[2])
        else $error("w pivot flagged degenerate");

    // skid only fills behind a held output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full without output beat");

    // a beat leaving the pipeline while output is held must land in the skid
    assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("beat dropped at output");

endmodule
